### design/pvsa_pkg.sv
`default_nettype none

package pvsa_pkg;

    // Default sizes of the two cell rows.
    localparam int NUM_VOICES_DEF = 24;
    localparam int NUM_TRACKS_DEF = 32;

    // Field widths fixed by the interface.
    localparam int KIND_W  = 3;
    localparam int VOICE_W = 5;
    localparam int TRACK_W = 5;
    localparam int PRIO_W  = 16;
    localparam int MASK_W  = 32;

    // A priority of this value marks a voice as free.
    localparam logic signed [PRIO_W-1:0] PRIO_FREE = 16'sh7FFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET_PRIO  = 3'd0,
        KIND_SET_TRACK = 3'd1,
        KIND_ALLOC     = 3'd2,
        KIND_RELEASE   = 3'd3,
        KIND_CHECK     = 3'd4,
        KIND_BUILD     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_VSCAN,
        ST_TSCAN,
        ST_RELEASE,
        ST_FINISH
    } state_t;

    // Running best candidate handed along the voice row.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [VOICE_W-1:0]       idx;
    } cand_t;

    // Running check and build result handed along the track row.
    typedef struct packed {
        logic              hit;
        logic [MASK_W-1:0] mask;
    } trk_acc_t;

    // Control broadcast from the sequencer to every track cell.
    typedef struct packed {
        logic               wr_en;
        logic               wr_sec;
        logic [TRACK_W-1:0] wr_track;
        logic [VOICE_W-1:0] wr_voice;
        logic               rel_en;
        logic               rel_sec;
        logic [VOICE_W-1:0] rel_voice;
        logic               scan_sec;
        logic [VOICE_W-1:0] scan_voice;
    } trk_ctl_t;

endpackage

`default_nettype wire

### design/priority_voice_steal_allocator_core.sv
`default_nettype none

// Lowest-priority voice stealing allocator. The block holds a signed priority
// for each voice in a row of voice cells, and a primary and a secondary voice
// assignment for each track in a row of track cells. One word is taken on the
// input channel at a time and gives exactly one result word. Priority writes,
// track writes, releases and the no-operation kinds pass an execute step and
// a finish step that loads the result. Allocate runs a candidate through the
// voice row, one cell per cycle, and then clears the chosen voice from the
// track tables. Check and build run an accumulator through the track row,
// one cell per cycle. The next word is accepted in the cycle after a result
// is loaded into the output register, even while that result still waits to
// be taken. The secondary table is cleared by a release only while the
// enable bit written through cfg_we and cfg_wdata is set; the register may
// be written at any time while the block is idle.
module priority_voice_steal_allocator_core #(
    parameter int NUM_VOICES = pvsa_pkg::NUM_VOICES_DEF,
    parameter int NUM_TRACKS = pvsa_pkg::NUM_TRACKS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [pvsa_pkg::KIND_W-1:0]         kind,
    input  wire logic [pvsa_pkg::VOICE_W-1:0]        voice,
    input  wire logic [pvsa_pkg::TRACK_W-1:0]        track,
    input  wire logic                                table_select,
    input  wire logic signed [pvsa_pkg::PRIO_W-1:0]  priority_req,
    input  wire logic [pvsa_pkg::MASK_W-1:0]         track_mask,
    input  wire logic [pvsa_pkg::MASK_W-1:0]         prior_mask,
    input  wire logic [pvsa_pkg::MASK_W-1:0]         final_mask,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [pvsa_pkg::VOICE_W-1:0]             chosen_voice,
    output logic                                     hit,
    output logic [pvsa_pkg::MASK_W-1:0]              voice_mask,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_wdata
);

    localparam int SCAN_MAX = (NUM_VOICES > NUM_TRACKS) ? NUM_VOICES : NUM_TRACKS;
    localparam int SCAN_W   = (SCAN_MAX > 2) ? $clog2(SCAN_MAX) : 1;
    localparam logic [pvsa_pkg::VOICE_W-1:0] VOICE_NONE = pvsa_pkg::VOICE_W'(NUM_VOICES);

    // Sequencer state.
    pvsa_pkg::state_t state_reg;
    pvsa_pkg::state_t state_next;
    logic [SCAN_W-1:0] cnt_reg;
    logic [SCAN_W-1:0] cnt_next;
    logic              sec_en_reg;

    // The accepted word, held for the whole operation.
    pvsa_pkg::kind_t                     kind_reg;
    logic [pvsa_pkg::VOICE_W-1:0]        voice_reg;
    logic [pvsa_pkg::TRACK_W-1:0]        track_reg;
    logic                                sel_reg;
    logic signed [pvsa_pkg::PRIO_W-1:0]  prio_reg;
    logic [pvsa_pkg::MASK_W-1:0]         tmask_reg;
    logic [pvsa_pkg::MASK_W-1:0]         pmask_reg;
    logic [pvsa_pkg::MASK_W-1:0]         fmask_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [pvsa_pkg::VOICE_W-1:0]        chosen_reg;
    logic                                hit_reg;
    logic [pvsa_pkg::MASK_W-1:0]         vmask_reg;

    logic                 in_accept;
    logic                 out_load;
    logic                 can_load;
    logic                 voice_wr_en;
    logic                 winner_valid;
    pvsa_pkg::trk_ctl_t   trk_ctl;

    pvsa_pkg::cand_t      cand_chain [NUM_VOICES+1];
    pvsa_pkg::trk_acc_t   acc_chain  [NUM_TRACKS+1];

    assign in_stall  = (state_reg != pvsa_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            sec_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            sec_en_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= pvsa_pkg::kind_t'(kind);
            voice_reg <= voice;
            track_reg <= track;
            sel_reg   <= table_select;
            prio_reg  <= priority_req;
            tmask_reg <= track_mask;
            pmask_reg <= prior_mask;
            fmask_reg <= final_mask;
        end
    end

    // The seeds enter the heads of both rows; the tails carry the results.
    assign cand_chain[0].prio = pvsa_pkg::PRIO_FREE;
    assign cand_chain[0].idx  = VOICE_NONE;
    assign acc_chain[0].hit   = 1'b0;
    assign acc_chain[0].mask  = '0;

    // A candidate that is still free means no voice is in use.
    assign winner_valid = (cand_chain[NUM_VOICES].prio != pvsa_pkg::PRIO_FREE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= pvsa_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        out_load    = 1'b0;
        voice_wr_en = 1'b0;

        trk_ctl            = '0;
        trk_ctl.wr_sec     = sel_reg;
        trk_ctl.wr_track   = track_reg;
        trk_ctl.wr_voice   = voice_reg;
        trk_ctl.rel_sec    = sec_en_reg;
        trk_ctl.rel_voice  = voice_reg;
        trk_ctl.scan_sec   = sel_reg;
        trk_ctl.scan_voice = voice_reg;

        case (state_reg)
            pvsa_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    case (pvsa_pkg::kind_t'(kind))
                        pvsa_pkg::KIND_ALLOC:
                        begin
                            state_next = pvsa_pkg::ST_VSCAN;
                        end
                        pvsa_pkg::KIND_CHECK, pvsa_pkg::KIND_BUILD:
                        begin
                            state_next = pvsa_pkg::ST_TSCAN;
                        end
                        default:
                        begin
                            state_next = pvsa_pkg::ST_EXEC;
                        end
                    endcase
                end
            end
            pvsa_pkg::ST_EXEC:
            begin
                // Updates of the stored tables.
                case (kind_reg)
                    pvsa_pkg::KIND_SET_PRIO:
                    begin
                        voice_wr_en = 1'b1;
                    end
                    pvsa_pkg::KIND_SET_TRACK:
                    begin
                        trk_ctl.wr_en = 1'b1;
                    end
                    pvsa_pkg::KIND_RELEASE:
                    begin
                        trk_ctl.rel_en = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = pvsa_pkg::ST_FINISH;
            end
            pvsa_pkg::ST_VSCAN:
            begin
                // The scan runs until the candidate has left the last voice cell.
                cnt_next = cnt_reg + SCAN_W'(1);
                if (cnt_reg == SCAN_W'(NUM_VOICES - 1))
                begin
                    state_next = pvsa_pkg::ST_RELEASE;
                end
            end
            pvsa_pkg::ST_TSCAN:
            begin
                cnt_next = cnt_reg + SCAN_W'(1);
                if (cnt_reg == SCAN_W'(NUM_TRACKS - 1))
                begin
                    state_next = pvsa_pkg::ST_FINISH;
                end
            end
            pvsa_pkg::ST_RELEASE:
            begin
                // Priorities are not touched, so the row tail stays valid.
                trk_ctl.rel_en    = winner_valid;
                trk_ctl.rel_voice = cand_chain[NUM_VOICES].idx;
                state_next        = pvsa_pkg::ST_FINISH;
            end
            pvsa_pkg::ST_FINISH:
            begin
                if (can_load)
                begin
                    out_load   = 1'b1;
                    state_next = pvsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pvsa_pkg::ST_IDLE;
            end
        endcase
    end

    genvar gv;
    generate
        for (gv = 0; gv < NUM_VOICES; gv++)
        begin : g_voice
            pvsa_voice_cell #(
                .CELL_IDX (gv)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_en    (voice_wr_en),
                .wr_voice (voice_reg),
                .wr_prio  (prio_reg),
                .cand_in  (cand_chain[gv]),
                .cand_out (cand_chain[gv+1])
            );
        end

        for (gv = 0; gv < NUM_TRACKS; gv++)
        begin : g_track
            pvsa_track_cell #(
                .CELL_IDX   (gv),
                .NUM_VOICES (NUM_VOICES)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (trk_ctl),
                .sel_bit (tmask_reg[gv]),
                .acc_in  (acc_chain[gv]),
                .acc_out (acc_chain[gv+1])
            );
        end
    endgenerate

    // Result fields that do not belong to the kind read as their defaults.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            chosen_reg <= VOICE_NONE;
            hit_reg    <= 1'b0;
            vmask_reg  <= '0;
            case (kind_reg)
                pvsa_pkg::KIND_ALLOC:
                begin
                    if (winner_valid)
                    begin
                        chosen_reg <= cand_chain[NUM_VOICES].idx;
                    end
                end
                pvsa_pkg::KIND_CHECK:
                begin
                    hit_reg <= acc_chain[NUM_TRACKS].hit;
                end
                pvsa_pkg::KIND_BUILD:
                begin
                    vmask_reg <= (pmask_reg | acc_chain[NUM_TRACKS].mask) & fmask_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign chosen_voice = chosen_reg;
    assign hit          = hit_reg;
    assign voice_mask   = vmask_reg;

    // A result appears only when the sequencer finishes an operation.
    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == pvsa_pkg::ST_FINISH))
        else $error("result loaded outside the finish step");

    // The voice scan never runs past the end of the voice row.
    a_vscan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pvsa_pkg::ST_VSCAN) |-> (cnt_reg <= SCAN_W'(NUM_VOICES - 1)))
        else $error("voice scan counter out of range");

    // A voice in use found by the scan is always a real voice.
    a_winner_real: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pvsa_pkg::ST_RELEASE && winner_valid)
        |-> ({1'b0, cand_chain[NUM_VOICES].idx} < (pvsa_pkg::VOICE_W+1)'(NUM_VOICES)))
        else $error("allocate picked a voice outside the row");

    // An accepted word always starts the sequencer away from idle.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != pvsa_pkg::ST_IDLE))
        else $error("accepted word did not start an operation");

endmodule

`default_nettype wire

### design/pvsa_voice_cell.sv
`default_nettype none

// One voice: holds its priority and passes the lower of its own priority and
// the incoming candidate on to the next cell, one cell per clock.
module pvsa_voice_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 wr_en,
    input  wire logic [pvsa_pkg::VOICE_W-1:0]         wr_voice,
    input  wire logic signed [pvsa_pkg::PRIO_W-1:0]   wr_prio,
    input  wire pvsa_pkg::cand_t                      cand_in,
    output pvsa_pkg::cand_t                           cand_out
);

    logic signed [pvsa_pkg::PRIO_W-1:0] prio_reg;
    pvsa_pkg::cand_t                    cand_reg;
    pvsa_pkg::cand_t                    cand_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            prio_reg <= pvsa_pkg::PRIO_FREE;
        end
        else if (wr_en && (wr_voice == pvsa_pkg::VOICE_W'(CELL_IDX)))
        begin
            prio_reg <= wr_prio;
        end
    end

    // Strictly lower wins, so on a tie the earlier voice is kept.
    always_comb
    begin
        cand_next = cand_in;
        if (prio_reg < cand_in.prio)
        begin
            cand_next.prio = prio_reg;
            cand_next.idx  = pvsa_pkg::VOICE_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

`default_nettype wire

### design/pvsa_track_cell.sv
`default_nettype none

// One track: holds its primary and secondary voice assignment, clears them on
// release (secondary if rel_sec), adds its share to the check/build result.
module pvsa_track_cell #(
    parameter int CELL_IDX   = 0,
    parameter int NUM_VOICES = pvsa_pkg::NUM_VOICES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pvsa_pkg::trk_ctl_t  ctl,
    input  wire logic                sel_bit,
    input  wire pvsa_pkg::trk_acc_t  acc_in,
    output pvsa_pkg::trk_acc_t       acc_out
);

    localparam logic [pvsa_pkg::VOICE_W-1:0] VOICE_NONE = pvsa_pkg::VOICE_W'(NUM_VOICES);

    logic [pvsa_pkg::VOICE_W-1:0] prim_reg;
    logic [pvsa_pkg::VOICE_W-1:0] prim_next;
    logic [pvsa_pkg::VOICE_W-1:0] sec_reg;
    logic [pvsa_pkg::VOICE_W-1:0] sec_next;
    logic [pvsa_pkg::VOICE_W-1:0] entry;
    logic                         wr_here;
    pvsa_pkg::trk_acc_t           acc_reg;
    pvsa_pkg::trk_acc_t           acc_next;

    assign wr_here = ctl.wr_en && (ctl.wr_track == pvsa_pkg::TRACK_W'(CELL_IDX));

    always_comb
    begin
        prim_next = prim_reg;
        sec_next  = sec_reg;
        if (wr_here && !ctl.wr_sec)
        begin
            prim_next = ctl.wr_voice;
        end
        if (wr_here && ctl.wr_sec)
        begin
            sec_next = ctl.wr_voice;
        end
        if (ctl.rel_en && (prim_reg == ctl.rel_voice))
        begin
            prim_next = VOICE_NONE;
        end
        if (ctl.rel_en && ctl.rel_sec && (sec_reg == ctl.rel_voice))
        begin
            sec_next = VOICE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            prim_reg <= VOICE_NONE;
            sec_reg  <= VOICE_NONE;
        end
        else
        begin
            prim_reg <= prim_next;
            sec_reg  <= sec_next;
        end
    end

    assign entry = ctl.scan_sec ? sec_reg : prim_reg;

    always_comb
    begin
        acc_next = acc_in;
        if (sel_bit && (entry == ctl.scan_voice))
        begin
            acc_next.hit = 1'b1;
        end
        if (sel_bit && ({1'b0, entry} < (pvsa_pkg::VOICE_W+1)'(NUM_VOICES)))
        begin
            acc_next.mask = acc_in.mask | (pvsa_pkg::MASK_W'(1) << entry);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_out = acc_reg;

endmodule

`default_nettype wire
